// ===== hw/rtl/rrt_pkg.sv =====
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared types, codes and constants of the request/response tracker.
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 25;
  localparam int EXTRA_W     = 20;

  // func codes
  localparam logic [2:0] FN_SEND  = 3'd0;
  localparam logic [2:0] FN_RECV  = 3'd1;
  localparam logic [2:0] FN_TICK  = 3'd2;
  localparam logic [2:0] FN_QUERY = 3'd3;
  localparam logic [2:0] FN_CLEAR = 3'd4;

  // message direction codes
  localparam logic [1:0] DIR_CONFIRM  = 2'd1;
  localparam logic [1:0] DIR_RESPONSE = 2'd2;

  // request status codes
  localparam logic [2:0] ST_CREATED   = 3'd0;
  localparam logic [2:0] ST_SENT      = 3'd1;
  localparam logic [2:0] ST_CONFIRMED = 3'd2;
  localparam logic [2:0] ST_BCAST     = 3'd3;
  localparam logic [2:0] ST_PROCESSED = 3'd4;
  localparam logic [2:0] ST_TIMEOUT   = 3'd5;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_DIR      = 3'd1;
  localparam logic [2:0] ERR_IDLE     = 3'd2;
  localparam logic [2:0] ERR_PERIPH   = 3'd3;
  localparam logic [2:0] ERR_COMMAND  = 3'd4;
  localparam logic [2:0] ERR_SENT     = 3'd5;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_BASE_TIMEOUT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOW_POWER    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BCAST_ADDR   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] BASE_TIMEOUT_RST = '1;
  localparam logic [15:0]           BCAST_ADDR_RST   = 16'd255;

  // response slot estimate
  localparam logic [7:0]  SLOT_FIXED     = 8'd20;
  localparam logic [7:0]  RESP_FIXED_MS  = 8'd200;
  localparam logic [7:0]  RESP_STD_MS    = 8'd50;
  localparam logic [7:0]  RESP_LP_MS     = 8'd100;
  localparam logic [EXTRA_W-1:0] EST_OVERHEAD_MS = 20'd40;
  localparam logic [7:0]  CMD_MASK       = 8'h7f;

  typedef struct packed {
    logic [7:0]  slot_length;
    logic [7:0]  hops_back;
    logic [7:0]  hops;
    logic [7:0]  command;
    logic [7:0]  peripheral;
    logic [15:0] node_address;
    logic [1:0]  direction;
    logic [2:0]  func;
  } item_t;

  typedef struct packed {
    logic [EXTRA_W-1:0] extra;
    item_t              item;
  } est_item_t;

endpackage

// ===== hw/rtl/request_response_tracker.sv =====
// ----------------------------------------------------------------------------
// request_response_tracker
// Tracks one outstanding mesh request from send to response or timeout.
// ----------------------------------------------------------------------------
//  port group   dir   contents
//  in_*         in    request: tuser = func, tdata = direction..slot_length
//  out_*        out   result: status, error, remaining_ms, in_progress
//  cfg_*        in    register write: base timeout, low power mode, bcast addr
//
//  One request per cycle while out_tready does not stall.
//  Stages: input register, estimate multiply register, state/result register.
//  rst_n (sync) clears state, valid flags and config registers to their defaults.
//  A stalled out_tready holds each stage; in_tready drops once all are full.
// ----------------------------------------------------------------------------
module request_response_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] direction, [17:2] node_address, [25:18] peripheral, [33:26] command,
  // [41:34] hops, [49:42] hops_back, [57:50] slot_length, rest zero
  input  logic [rrt_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [2:0] func
  input  logic [rrt_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [2:0] status, [5:3] error, [37:6] remaining_ms, [38] in_progress, rest zero
  output logic [rrt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_we,
  input  logic [rrt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rrt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rrt_pkg::*;

  logic signed [CFG_DATA_W-1:0] base_timeout_r;
  logic                         low_power_r;
  logic [15:0]                  bcast_addr_r;

  item_t              in_item;
  logic               est_valid;
  logic               est_ready;
  est_item_t          est_item;
  logic [2:0]         res_status;
  logic [2:0]         res_error;
  logic signed [31:0] res_remain;
  logic               res_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_timeout_r <= BASE_TIMEOUT_RST;
      low_power_r    <= 1'b0;
      bcast_addr_r   <= BCAST_ADDR_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BASE_TIMEOUT: base_timeout_r <= cfg_wdata;
        CFG_LOW_POWER:    low_power_r    <= cfg_wdata[0];
        CFG_BCAST_ADDR:   bcast_addr_r   <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_item.func         = in_tuser;
    in_item.direction    = in_tdata[1:0];
    in_item.node_address = in_tdata[17:2];
    in_item.peripheral   = in_tdata[25:18];
    in_item.command      = in_tdata[33:26];
    in_item.hops         = in_tdata[41:34];
    in_item.hops_back    = in_tdata[49:42];
    in_item.slot_length  = in_tdata[57:50];
  end

  rrt_est u_est (
    .clk            (clk),
    .rst_n          (rst_n),
    .low_power_mode (low_power_r),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_item        (in_item),
    .est_valid      (est_valid),
    .est_ready      (est_ready),
    .est_item       (est_item)
  );

  rrt_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .base_timeout_ms   (base_timeout_r),
    .broadcast_address (bcast_addr_r),
    .est_valid         (est_valid),
    .est_ready         (est_ready),
    .est_item          (est_item),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_status        (res_status),
    .out_error         (res_error),
    .out_remaining     (res_remain),
    .out_in_progress   (res_busy)
  );

  assign out_tdata = {1'b0, res_busy, res_remain, res_error, res_status};

endmodule

// ===== hw/rtl/rrt_est.sv =====
// ----------------------------------------------------------------------------
// rrt_est
// Request input register and hop-based timeout estimate stage.
// ----------------------------------------------------------------------------
module rrt_est (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              low_power_mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrt_pkg::item_t    in_item,
  output logic              est_valid,
  input  logic              est_ready,
  output rrt_pkg::est_item_t est_item
);
  import rrt_pkg::*;

  logic      s0_valid_r;
  item_t     s0_item_r;
  logic      s1_valid_r;
  est_item_t s1_item_r;
  logic      s1_ready;
  logic      s0_ready;

  logic [8:0]         hops_p1;
  logic [8:0]         back_p1;
  logic [16:0]        slot_prod;
  logic [19:0]        slot_ms;
  logic [7:0]         resp_ms;
  logic [16:0]        resp_total;
  logic [EXTRA_W-1:0] extra;

  assign s1_ready = !s1_valid_r || est_ready;
  assign s0_ready = !s0_valid_r || s1_ready;
  assign in_ready = s0_ready;

  assign est_valid = s1_valid_r;
  assign est_item  = s1_item_r;

  always_comb begin
    hops_p1   = {1'b0, s0_item_r.hops} + 9'd1;
    back_p1   = {1'b0, s0_item_r.hops_back} + 9'd1;
    slot_prod = {8'd0, hops_p1} * {9'd0, s0_item_r.slot_length};
    // slot length is in tens of ms: x10 = x8 + x2
    slot_ms   = {slot_prod, 3'b000} + {2'b00, slot_prod, 1'b0};
    if (s0_item_r.slot_length == SLOT_FIXED) begin
      resp_ms = RESP_FIXED_MS;
    end else if (low_power_mode) begin
      resp_ms = RESP_LP_MS;
    end else begin
      resp_ms = RESP_STD_MS;
    end
    resp_total = {8'd0, back_p1} * {9'd0, resp_ms};
    extra      = slot_ms + {3'b000, resp_total} + EST_OVERHEAD_MS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid_r <= in_valid;
      end
      if (s1_ready) begin
        s1_valid_r <= s0_valid_r;
      end
    end
    if (s0_ready && in_valid) begin
      s0_item_r <= in_item;
    end
    if (s1_ready && s0_valid_r) begin
      s1_item_r.item  <= s0_item_r;
      s1_item_r.extra <= extra;
    end
  end

endmodule

// ===== hw/rtl/rrt_core.sv =====
// ----------------------------------------------------------------------------
// rrt_core
// Request state update and result register.
// ----------------------------------------------------------------------------
module rrt_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic signed [rrt_pkg::CFG_DATA_W-1:0] base_timeout_ms,
  input  logic [15:0]                      broadcast_address,
  input  logic                             est_valid,
  output logic                             est_ready,
  input  rrt_pkg::est_item_t               est_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_status,
  output logic [2:0]                       out_error,
  output logic signed [31:0]               out_remaining,
  output logic                             out_in_progress
);
  import rrt_pkg::*;

  logic [2:0]         status_r,   status_nxt;
  logic [7:0]         sent_per_r, sent_per_nxt;
  logic [7:0]         sent_cmd_r, sent_cmd_nxt;
  logic signed [31:0] deadline_r, deadline_nxt;
  logic [31:0]        elapsed_r,  elapsed_nxt;

  logic               out_valid_r;
  logic [2:0]         res_status_r;
  logic [2:0]         res_error_r;
  logic signed [31:0] res_remain_r;
  logic               res_busy_r;

  logic [2:0]         err;
  logic signed [31:0] remain;
  logic               arm;
  logic [EXTRA_W-1:0] arm_extra;
  logic signed [33:0] diff;
  logic               base_forever;
  logic               busy_now;
  item_t              it;

  assign it        = est_item.item;
  assign est_ready = !out_valid_r || out_ready;

  assign base_forever = (base_timeout_ms == BASE_TIMEOUT_RST);
  assign busy_now     = (status_r == ST_SENT) || (status_r == ST_CONFIRMED);
  assign diff = {{2{deadline_r[31]}}, deadline_r} - $signed({2'b00, elapsed_r});

  always_comb begin
    status_nxt   = status_r;
    sent_per_nxt = sent_per_r;
    sent_cmd_nxt = sent_cmd_r;
    deadline_nxt = deadline_r;
    elapsed_nxt  = elapsed_r;
    err          = ERR_NONE;
    remain       = '0;
    arm          = 1'b0;
    arm_extra    = '0;
    case (it.func)
      FN_SEND: begin
        if (status_r != ST_CREATED) begin
          err = ERR_SENT;
        end else begin
          status_nxt   = ST_SENT;
          sent_per_nxt = it.peripheral;
          sent_cmd_nxt = it.command;
          arm          = 1'b1;
        end
      end
      FN_RECV: begin
        if (it.direction != DIR_CONFIRM && it.direction != DIR_RESPONSE) begin
          err = ERR_DIR;
        end else if (!busy_now) begin
          err = ERR_IDLE;
        end else if (it.peripheral != sent_per_r) begin
          err = ERR_PERIPH;
        end else if ((it.command & CMD_MASK) != sent_cmd_r) begin
          err = ERR_COMMAND;
        end else if (it.direction == DIR_CONFIRM) begin
          status_nxt = (it.node_address == broadcast_address) ? ST_BCAST : ST_CONFIRMED;
          arm        = 1'b1;
          arm_extra  = est_item.extra;
        end else begin
          status_nxt = ST_PROCESSED;
        end
      end
      FN_TICK: begin
        if (elapsed_r != '1) begin
          elapsed_nxt = elapsed_r + 32'd1;
        end
      end
      FN_QUERY: begin
        if (status_r == ST_BCAST) begin
          status_nxt = ST_PROCESSED;
        end else if (busy_now || status_r == ST_TIMEOUT) begin
          if (deadline_r != -32'sd1) begin
            // saturate below at the most negative 32-bit value
            if (diff < -34'sh0_8000_0000) begin
              remain = 32'sh8000_0000;
            end else begin
              remain = diff[31:0];
            end
            if (diff[33]) begin
              status_nxt = ST_TIMEOUT;
            end
          end
        end
      end
      FN_CLEAR: begin
        status_nxt   = ST_CREATED;
        sent_per_nxt = '0;
        sent_cmd_nxt = '0;
        deadline_nxt = '0;
        elapsed_nxt  = '0;
      end
      default: begin
      end
    endcase
    if (arm) begin
      if (status_nxt != ST_BCAST && base_forever) begin
        deadline_nxt = -32'sd1;
      end else begin
        elapsed_nxt  = '0;
        deadline_nxt = 32'(base_timeout_ms) + $signed({12'd0, arm_extra});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= ST_CREATED;
      sent_per_r  <= '0;
      sent_cmd_r  <= '0;
      deadline_r  <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (est_ready) begin
        out_valid_r <= est_valid;
      end
      if (est_ready && est_valid) begin
        status_r   <= status_nxt;
        sent_per_r <= sent_per_nxt;
        sent_cmd_r <= sent_cmd_nxt;
        deadline_r <= deadline_nxt;
        elapsed_r  <= elapsed_nxt;
      end
    end
    if (est_ready && est_valid) begin
      res_status_r <= status_nxt;
      res_error_r  <= err;
      res_remain_r <= remain;
      res_busy_r   <= (status_nxt == ST_SENT) || (status_nxt == ST_CONFIRMED);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_status_r;
  assign out_error       = res_error_r;
  assign out_remaining   = res_remain_r;
  assign out_in_progress = res_busy_r;

endmodule
